// File: rtl/hia_pkg.sv
// Shared types, sizes and search functions for the id allocator.
package hia_pkg;

    localparam int SLOT_BITS  = 5;
    localparam int LEVELS     = 2;
    localparam int ID_BITS    = SLOT_BITS * LEVELS;
    localparam int LEAF_BITS  = ID_BITS - SLOT_BITS;
    localparam int SLOT_SIZE  = 1 << SLOT_BITS;
    localparam int LEAF_COUNT = 1 << LEAF_BITS;
    localparam int ID_COUNT   = 1 << ID_BITS;
    localparam int PORT_VALUE_BITS = 32;

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [LEAF_BITS-1:0]  leaf_idx_t;
    typedef logic [SLOT_BITS-1:0]  slot_idx_t;
    typedef logic [SLOT_SIZE-1:0]  leaf_word_t;
    typedef logic [LEAF_COUNT-1:0] summary_t;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    typedef struct packed {
        logic       re;
        logic       we;
        leaf_idx_t  addr;
        leaf_word_t wdata;
    } leaf_req_t;

    typedef struct packed {
        logic re;
        logic we;
        id_t  addr;
    } val_req_t;

    function automatic slot_idx_t lowest_slot(input leaf_word_t x);
        slot_idx_t idx;
        idx = '0;
        for (int i = SLOT_SIZE - 1; i >= 0; i--) begin
            if (x[i])
            begin
                idx = slot_idx_t'(i);
            end
        end
        return idx;
    endfunction

    function automatic leaf_idx_t lowest_leaf(input summary_t x);
        leaf_idx_t idx;
        idx = '0;
        for (int i = LEAF_COUNT - 1; i >= 0; i--) begin
            if (x[i])
            begin
                idx = leaf_idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/hia_ram.sv
// Generic single-port synchronous RAM with registered read data.
module hia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hia_ctrl.sv
// Command sequencer: leaf bitmap read-modify-write, summary search, result register.
module hia_ctrl
    import hia_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  id_t                        base_id,
    input  id_t                        key_id,
    input  logic [PORT_VALUE_BITS-1:0] value_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output id_t                        id_out,
    output logic [PORT_VALUE_BITS-1:0] value_out,
    output logic                       hit,
    output leaf_req_t                  leaf_req,
    input  leaf_word_t                 leaf_rdata,
    output val_req_t                   val_req,
    output logic [VALUE_BITS-1:0]      val_wdata,
    input  logic [VALUE_BITS-1:0]      val_rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_LOOK2 = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    cmd_t                       cmd_reg, cmd_next;
    leaf_idx_t                  leaf_reg, leaf_next;
    slot_idx_t                  off_reg, off_next;
    slot_idx_t                  kslot_reg, kslot_next;
    logic [PORT_VALUE_BITS-1:0] value_reg, value_next;
    summary_t                   vld_reg, vld_next;
    summary_t                   full_reg, full_next;
    status_t                    res_status_reg, res_status_next;
    id_t                        res_id_reg, res_id_next;
    logic                       res_hit_reg, res_hit_next;
    logic                       out_valid_reg, out_valid_next;
    status_t                    status_reg, status_next;
    id_t                        id_out_reg, id_out_next;
    logic [PORT_VALUE_BITS-1:0] value_out_reg, value_out_next;
    logic                       hit_reg, hit_next;

    logic       accept;
    logic       emit;
    leaf_word_t used;
    leaf_word_t off_mask;
    leaf_word_t avail;
    leaf_word_t new_used;
    slot_idx_t  slot;
    summary_t   cand;
    leaf_idx_t  nleaf;
    logic       key_used;
    logic [63:0] val_wide;
    logic [63:0] rd_wide;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign used     = vld_reg[leaf_reg] ? leaf_rdata : '0;
    assign off_mask = (state_reg == S_LOOK) ? ({SLOT_SIZE{1'b1}} << off_reg)
                                            : {SLOT_SIZE{1'b1}};
    assign avail    = ~used & off_mask;
    assign slot     = lowest_slot(avail);
    assign new_used = used | (leaf_word_t'(1) << slot);
    assign cand     = ~full_reg & (({LEAF_COUNT{1'b1}} << leaf_reg) << 1);
    assign nleaf    = lowest_leaf(cand);
    assign key_used = used[kslot_reg];
    assign val_wide = 64'(value_reg);
    assign rd_wide  = 64'(val_rdata);
    assign val_wdata = val_wide[VALUE_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        leaf_next       = leaf_reg;
        off_next        = off_reg;
        kslot_next      = kslot_reg;
        value_next      = value_reg;
        vld_next        = vld_reg;
        full_next       = full_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_hit_next    = res_hit_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        id_out_next     = id_out_reg;
        value_out_next  = value_out_reg;
        hit_next        = hit_reg;
        leaf_req        = '0;
        val_req         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_t'(command);
                    off_next   = base_id[SLOT_BITS-1:0];
                    kslot_next = key_id[SLOT_BITS-1:0];
                    value_next = value_in;
                    if (cmd_t'(command) == CMD_ALLOC)
                    begin
                        leaf_next = base_id[ID_BITS-1:SLOT_BITS];
                    end
                    else
                    begin
                        leaf_next = key_id[ID_BITS-1:SLOT_BITS];
                    end
                    leaf_req.re   = 1'b1;
                    leaf_req.addr = leaf_next;
                    state_next    = S_LOOK;
                end
            end
            S_LOOK, S_LOOK2:
            begin
                res_status_next = ST_OK;
                res_id_next     = '0;
                res_hit_next    = 1'b0;
                state_next      = S_EMIT;
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (|avail)
                        begin
                            leaf_req.we    = 1'b1;
                            leaf_req.addr  = leaf_reg;
                            leaf_req.wdata = new_used;
                            val_req.we     = 1'b1;
                            val_req.addr   = {leaf_reg, slot};
                            vld_next[leaf_reg] = 1'b1;
                            if (&new_used)
                            begin
                                full_next[leaf_reg] = 1'b1;
                            end
                            res_id_next = {leaf_reg, slot};
                        end
                        else if ((state_reg == S_LOOK) && (|cand))
                        begin
                            leaf_next     = nleaf;
                            leaf_req.re   = 1'b1;
                            leaf_req.addr = nleaf;
                            state_next    = S_LOOK2;
                        end
                        else
                        begin
                            res_status_next = ST_NO_SPACE;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (key_used)
                        begin
                            leaf_req.we    = 1'b1;
                            leaf_req.addr  = leaf_reg;
                            leaf_req.wdata = used & ~(leaf_word_t'(1) << kslot_reg);
                            vld_next[leaf_reg]  = 1'b1;
                            full_next[leaf_reg] = 1'b0;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_ALLOC;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (key_used)
                        begin
                            val_req.re   = 1'b1;
                            val_req.addr = {leaf_reg, kslot_reg};
                            res_hit_next = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_ALLOC;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    id_out_next    = res_id_reg;
                    hit_next       = res_hit_reg;
                    value_out_next = res_hit_reg ? rd_wide[PORT_VALUE_BITS-1:0] : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        leaf_reg       <= leaf_next;
        off_reg        <= off_next;
        kslot_reg      <= kslot_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_hit_reg    <= res_hit_next;
        status_reg     <= status_next;
        id_out_reg     <= id_out_next;
        value_out_reg  <= value_out_next;
        hit_reg        <= hit_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign id_out    = id_out_reg;
    assign value_out = value_out_reg;
    assign hit       = hit_reg;

endmodule

// File: rtl/hierarchical_id_allocator_top.sv
// Sequence: leaf bitmap RAM read issued on accept, modify and write-back in S_LOOK (and S_LOOK2
//   when allocate moves to a further leaf), result register load in S_EMIT once the output is free.
//   A new item is accepted only in S_IDLE, so the block is busy until the previous one is out.
// Reset: leaf bitmaps read as empty through per-leaf valid flops and the full summary clears
//   at once; the value RAM is not cleared. No clearing pass.
module hierarchical_id_allocator_top
    import hia_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  id_t                        base_id,
    input  id_t                        key_id,
    input  logic [PORT_VALUE_BITS-1:0] value_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output id_t                        id_out,
    output logic [PORT_VALUE_BITS-1:0] value_out,
    output logic                       hit
);

    leaf_req_t              leaf_req;
    leaf_word_t             leaf_rdata;
    val_req_t               val_req;
    logic [VALUE_BITS-1:0]  val_wdata;
    logic [VALUE_BITS-1:0]  val_rdata;

    hia_ctrl #(
        .VALUE_BITS(VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .base_id   (base_id),
        .key_id    (key_id),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .id_out    (id_out),
        .value_out (value_out),
        .hit       (hit),
        .leaf_req  (leaf_req),
        .leaf_rdata(leaf_rdata),
        .val_req   (val_req),
        .val_wdata (val_wdata),
        .val_rdata (val_rdata)
    );

    hia_ram #(
        .WIDTH(SLOT_SIZE),
        .DEPTH(LEAF_COUNT)
    ) u_leaf_ram (
        .clk  (clk),
        .re   (leaf_req.re),
        .we   (leaf_req.we),
        .addr (leaf_req.addr),
        .wdata(leaf_req.wdata),
        .rdata(leaf_rdata)
    );

    hia_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(ID_COUNT)
    ) u_val_ram (
        .clk  (clk),
        .re   (val_req.re),
        .we   (val_req.we),
        .addr (val_req.addr),
        .wdata(val_wdata),
        .rdata(val_rdata)
    );

    a_leaf_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(leaf_req.re && leaf_req.we))
        else $error("leaf RAM read and write in the same cycle");

    a_val_with_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        val_req.we |-> (leaf_req.we && (val_req.addr[ID_BITS-1:SLOT_BITS] == leaf_req.addr)))
        else $error("value write without matching leaf update");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (status == ST_OK && id_out == '0))
        else $error("find hit with bad status or id");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while busy");

endmodule

// File: tb/sv/id_tracker_pkg.sv
// Scoreboard class that predicts allocator responses and checks the returned words.
package id_tracker_pkg;

    import hia_pkg::*;

    typedef struct packed {
        logic [1:0]                 status;
        id_t                        id;
        logic [PORT_VALUE_BITS-1:0] value;
        logic                       hit;
    } id_response_t;

    class id_tracker;
        leaf_word_t                 used_map [LEAF_COUNT];
        summary_t                   full_map;
        logic [PORT_VALUE_BITS-1:0] stored_value [ID_COUNT];
        id_response_t               expected_responses [$];
        int                         errors;

        function new();
            for (int i = 0; i < LEAF_COUNT; i++)
            begin
                used_map[i] = '0;
            end
            full_map = '0;
            errors   = 0;
        endfunction

        function int outstanding();
            return expected_responses.size();
        endfunction

        // first claimed id at or after from, wrapping past the top of the id range, -1 if none
        function int find_used(id_t from);
            int idx;
            for (int n = 0; n < ID_COUNT; n++)
            begin
                idx = (int'(from) + n) % ID_COUNT;
                if (used_map[idx / SLOT_SIZE][idx % SLOT_SIZE])
                begin
                    return idx;
                end
            end
            return -1;
        endfunction

        function void note_request(logic [1:0] cmd, id_t start, id_t key,
                                   logic [PORT_VALUE_BITS-1:0] val);
            id_response_t r;
            leaf_idx_t    leaf;
            leaf_idx_t    kleaf;
            slot_idx_t    kslot;
            slot_idx_t    slot;
            leaf_word_t   avail;
            leaf_word_t   mask;
            logic         found;
            r     = '0;
            kleaf = key[ID_BITS-1:SLOT_BITS];
            kslot = key[SLOT_BITS-1:0];
            case (cmd)
                CMD_ALLOC:
                begin
                    leaf  = start[ID_BITS-1:SLOT_BITS];
                    mask  = '1;
                    mask  = mask << start[SLOT_BITS-1:0];
                    avail = ~used_map[leaf] & mask;
                    if (avail == '0)
                    begin
                        found = 1'b0;
                        for (int l = int'(leaf) + 1; l < LEAF_COUNT && !found; l++)
                        begin
                            if (!full_map[l])
                            begin
                                leaf  = leaf_idx_t'(l);
                                avail = ~used_map[l];
                                found = 1'b1;
                            end
                        end
                    end
                    if (avail == '0)
                    begin
                        r.status = ST_NO_SPACE;
                    end
                    else
                    begin
                        found = 1'b0;
                        slot  = '0;
                        for (int i = 0; i < SLOT_SIZE; i++)
                        begin
                            if (!found && avail[i])
                            begin
                                slot  = slot_idx_t'(i);
                                found = 1'b1;
                            end
                        end
                        used_map[leaf][slot] = 1'b1;
                        if (&used_map[leaf])
                        begin
                            full_map[leaf] = 1'b1;
                        end
                        stored_value[{leaf, slot}] = val;
                        r.status = ST_OK;
                        r.id     = {leaf, slot};
                    end
                end
                CMD_REMOVE:
                begin
                    if (!used_map[kleaf][kslot])
                    begin
                        r.status = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        used_map[kleaf][kslot] = 1'b0;
                        full_map[kleaf]        = 1'b0;
                    end
                end
                CMD_FIND:
                begin
                    if (!used_map[kleaf][kslot])
                    begin
                        r.status = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        r.value = stored_value[key];
                        r.hit   = 1'b1;
                    end
                end
                default:
                begin
                    r = '0;
                end
            endcase
            expected_responses.push_back(r);
        endfunction

        function void check_response(logic [1:0] st, id_t id,
                                     logic [PORT_VALUE_BITS-1:0] val, logic h);
            id_response_t e;
            if (expected_responses.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected word: status=%0d id=%0d value=%h hit=%0d",
                             st, id, val, h);
                end
                return;
            end
            e = expected_responses.pop_front();
            if (st !== e.status || id !== e.id || val !== e.value || h !== e.hit)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected status=%0d id=%0d value=%h hit=%0d, got status=%0d id=%0d value=%h hit=%0d",
                             e.status, e.id, e.value, e.hit, st, id, val, h);
                end
            end
        endfunction
    endclass

endpackage

// File: tb/sv/tb.sv
// Top-level testbench for the hierarchical id allocator.
module tb;
    import hia_pkg::*;
    import id_tracker_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 8;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [1:0]                 command   = CMD_ALLOC;
    id_t                        base_id   = '0;
    id_t                        key_id    = '0;
    logic [PORT_VALUE_BITS-1:0] value_in  = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [1:0]                 status;
    id_t                        id_out;
    logic [PORT_VALUE_BITS-1:0] value_out;
    logic                       hit;

    id_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    hierarchical_id_allocator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .base_id   (base_id),
        .key_id    (key_id),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .id_out    (id_out),
        .value_out (value_out),
        .hit       (hit)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_response(status, id_out, value_out, hit);
        end
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic [1:0] c, input id_t s, input id_t k,
                             input logic [PORT_VALUE_BITS-1:0] v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        command  <= c;
        base_id  <= s;
        key_id   <= k;
        value_in <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        tracker.note_request(c, s, k, v);
    endtask

    task automatic send_random();
        int                         roll;
        int                         pick;
        logic [1:0]                 c;
        id_t                        s;
        id_t                        k;
        logic [PORT_VALUE_BITS-1:0] v;
        roll = $urandom_range(99);
        v    = $urandom;
        s    = id_t'($urandom);
        k    = id_t'($urandom);
        if (roll < 50)
        begin
            c    = CMD_ALLOC;
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                s = '0;
            end
            else if (pick < 6)
            begin
                s = id_t'(ID_COUNT - 1 - $urandom_range(63));
            end
            else if (pick < 8)
            begin
                s[SLOT_BITS-1:0] = '1;
            end
        end
        else if (roll < 72)
        begin
            c = CMD_REMOVE;
        end
        else if (roll < 96)
        begin
            c = CMD_FIND;
        end
        else
        begin
            c = CMD_RESERVED;
        end
        if ((c == CMD_REMOVE || c == CMD_FIND) && $urandom_range(4) != 0)
        begin
            pick = tracker.find_used(k);
            if (pick >= 0)
            begin
                k = id_t'(pick);
            end
        end
        send_word(c, s, k, v);
    endtask

    task automatic run_phase(input int count, input int s_idle, input int r_stall,
                             input int hold_at);
        send_idle_pct   = s_idle;
        recv_stall_pct <= r_stall;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
            begin
                hold_req <= hold_req + 1;
            end
            send_random();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty space, both ends of the id range, leaf crossing
        send_word(CMD_FIND,     10'd0,    10'd0,    32'h0000_0000);
        send_word(CMD_REMOVE,   10'd0,    10'd1023, 32'h0000_0000);
        send_word(CMD_ALLOC,    10'd0,    10'd0,    32'h0000_0000);
        send_word(CMD_ALLOC,    10'd0,    10'd1023, 32'hFFFF_FFFF);
        send_word(CMD_FIND,     10'd0,    10'd1,    32'h0000_0000);
        send_word(CMD_FIND,     10'd1023, 10'd0,    32'hFFFF_FFFF);
        send_word(CMD_ALLOC,    10'd1023, 10'd0,    32'hA5A5_A5A5);
        send_word(CMD_ALLOC,    10'd1023, 10'd0,    32'h5A5A_5A5A);
        send_word(CMD_ALLOC,    10'd1022, 10'd0,    32'h0000_0001);
        send_word(CMD_ALLOC,    10'd1022, 10'd0,    32'h8000_0000);
        send_word(CMD_RESERVED, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_word(CMD_REMOVE,   10'd0,    10'd1,    32'h0000_0000);
        send_word(CMD_REMOVE,   10'd0,    10'd1,    32'h0000_0000);
        send_word(CMD_FIND,     10'd0,    10'd1,    32'h0000_0000);
        send_word(CMD_ALLOC,    10'd0,    10'd0,    32'h1234_5678);
        send_word(CMD_FIND,     10'd0,    10'd1,    32'h0000_0000);
        send_word(CMD_ALLOC,    10'd31,   10'd0,    32'hDEAD_BEEF);
        send_word(CMD_ALLOC,    10'd31,   10'd0,    32'hCAFE_F00D);
        send_word(CMD_FIND,     10'd0,    10'd32,   32'h0000_0000);
        send_word(CMD_ALLOC,    10'd991,  10'd0,    32'h0F0F_0F0F);
        send_word(CMD_ALLOC,    10'd991,  10'd0,    32'hF0F0_F0F0);
        send_word(CMD_FIND,     10'd0,    10'd992,  32'h0000_0000);
        send_word(CMD_REMOVE,   10'd0,    10'd1023, 32'h0000_0000);
        send_word(CMD_FIND,     10'd0,    10'd1023, 32'h0000_0000);

        run_phase(420, 0,  0,  60);
        run_phase(420, 73, 0,  -1);
        run_phase(420, 0,  73, 200);
        run_phase(420, 9,  9,  -1);
        run_phase(250, 0,  0,  -1);

        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
